[rtl/bna_pkg.sv]
package bna_pkg;

   localparam int AMP_W         = 24;
   localparam int BIN_NUMBER_W  = 13;
   localparam int SPAN_W        = 6;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 40;
   localparam int RSP_PAD_W     = RSP_DATA_W - AMP_W - BIN_NUMBER_W;
   localparam int QUEUE_DEPTH   = 4;

   localparam int MAX_SPAN_DEF  = 63;
   localparam int MAX_BINS_DEF  = 8192;

   localparam logic [SPAN_W-1:0] HALF_WIDTH_RESET = SPAN_W'(4);
   localparam logic [SPAN_W-1:0] SPAN_RESET       = SPAN_W'(1);

endpackage

[rtl/bna_front.sv]
module bna_front
   import bna_pkg::*;
#(
   parameter int MaxSpan = MAX_SPAN_DEF,
   parameter int MaxBins = MAX_BINS_DEF,
   parameter int BinW    = $clog2(MaxBins)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SPAN_W-1:0] csr_wr_data,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [AMP_W-1:0]  req_tdata,
   input  logic              req_tlast,
   input  logic              q_full,
   output logic              q_push,
   output logic [AMP_W-1:0]  push_amp,
   output logic [BinW-1:0]   push_idx,
   output logic [SPAN_W-1:0] push_span,
   output logic              push_last
);

   logic [SPAN_W-1:0] half_width_ff, half_width_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [BinW-1:0]   bin_count_ff, bin_count_in;
   logic [SPAN_W-1:0] span_clamped;
   logic              frame_last;

   assign req_tready = !q_full && !reset;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      if (half_width_ff == '0) begin
         span_clamped = SPAN_W'(1);
      end else if (32'(half_width_ff) > MaxSpan) begin
         span_clamped = SPAN_W'(MaxSpan);
      end else begin
         span_clamped = half_width_ff;
      end
   end

   // span is latched on bin 0 so a mid-frame write only hits the next frame
   always_comb begin
      half_width_in = csr_wr_en ? csr_wr_data : half_width_ff;
      span_in       = span_ff;
      bin_count_in  = bin_count_ff;
      frame_last    = req_tlast || (bin_count_ff == BinW'(MaxBins - 1));
      if (q_push) begin
         if (bin_count_ff == '0) begin
            span_in = span_clamped;
         end
         bin_count_in = frame_last ? '0 : bin_count_ff + BinW'(1);
      end
   end

   assign push_amp  = req_tdata;
   assign push_idx  = bin_count_ff;
   assign push_span = (bin_count_ff == '0) ? span_clamped : span_ff;
   assign push_last = frame_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_WIDTH_RESET;
         span_ff       <= SPAN_RESET;
         bin_count_ff  <= '0;
      end else begin
         half_width_ff <= half_width_in;
         span_ff       <= span_in;
         bin_count_ff  <= bin_count_in;
      end
   end

endmodule

[rtl/bna_queue.sv]
module bna_queue
   import bna_pkg::*;
#(
   parameter int Width = 32,
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   input  logic             pop,
   output logic [Width-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = $clog2(Depth);

   logic [Width-1:0] entry_ff [Depth];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      level_ff, level_in;

   assign full     = (level_ff == (AW + 1)'(Depth));
   assign empty    = (level_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + (AW + 1)'(1);
      end else if (pop && !push) begin
         level_in = level_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

[rtl/bna_back.sv]
module bna_back
   import bna_pkg::*;
#(
   parameter int MaxSpan = MAX_SPAN_DEF,
   parameter int MaxBins = MAX_BINS_DEF,
   parameter int BinW    = $clog2(MaxBins),
   parameter int CntW    = $clog2(2 * MaxSpan + 2),
   parameter int SumW    = AMP_W + CntW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic [AMP_W-1:0]  q_amp,
   input  logic [BinW-1:0]   q_idx,
   input  logic [SPAN_W-1:0] q_span,
   input  logic              q_last,
   input  logic              div_ready,
   output logic              div_valid,
   output logic [SumW-1:0]   div_sum,
   output logic [CntW-1:0]   div_cnt,
   output logic [BinW-1:0]   div_bin,
   output logic              div_end
);

   localparam int Depth = 2 ** CntW;
   localparam int CmpW  = BinW + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADD  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_SUB  = 2'd3;

   logic [AMP_W-1:0]  store [Depth];
   logic [AMP_W-1:0]  rd_ff;
   logic              rd_en;
   logic [CntW-1:0]   rd_addr;

   logic [1:0]        state_ff, state_in;
   logic [AMP_W-1:0]  amp_ff, amp_in;
   logic [BinW-1:0]   idx_ff, idx_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic              last_ff, last_in;
   logic [BinW-1:0]   bin_ff, bin_in;
   logic [SumW-1:0]   sum_ff, sum_in;
   logic              sub_en_ff, sub_en_in;

   logic [CmpW-1:0]   q_idx_x, q_reach_x;
   logic [CmpW-1:0]   idx_x, span_x, bin_x, lo_x;

   assign q_idx_x   = CmpW'(q_idx);
   assign q_reach_x = (CmpW'(q_span) << 1) + CmpW'(1);
   assign idx_x     = CmpW'(idx_ff);
   assign span_x    = CmpW'(span_ff);
   assign bin_x     = CmpW'(bin_ff);
   assign lo_x      = (bin_x >= span_x) ? bin_x - span_x : '0;

   // window of the current bin always ends at the newest bin
   assign div_sum = sum_ff;
   assign div_cnt = CntW'(idx_x - lo_x + CmpW'(1));
   assign div_bin = bin_ff;
   assign div_end = last_ff && (bin_ff == idx_ff);

   always_comb begin
      state_in  = state_ff;
      amp_in    = amp_ff;
      idx_in    = idx_ff;
      span_in   = span_ff;
      last_in   = last_ff;
      bin_in    = bin_ff;
      sum_in    = sum_ff;
      sub_en_in = sub_en_ff;
      q_pop     = 1'b0;
      div_valid = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               amp_in    = q_amp;
               idx_in    = q_idx;
               span_in   = q_span;
               last_in   = q_last;
               // bin leaving the window: idx - (2*span + 1)
               rd_en     = 1'b1;
               rd_addr   = CntW'(q_idx_x - q_reach_x);
               sub_en_in = (q_idx_x >= q_reach_x);
               state_in  = ST_ADD;
            end
         end
         ST_ADD: begin
            sum_in = ((idx_ff == '0) ? '0 : sum_ff) + SumW'(amp_ff)
                     - (sub_en_ff ? SumW'(rd_ff) : '0);
            bin_in = (idx_x >= span_x) ? BinW'(idx_x - span_x) : '0;
            if (last_ff || (idx_x >= span_x)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            div_valid = 1'b1;
            if (div_ready) begin
               if (last_ff && (bin_ff != idx_ff)) begin
                  // flush: left edge of the window moves up by one
                  rd_en     = 1'b1;
                  rd_addr   = CntW'(bin_x - span_x);
                  sub_en_in = (bin_x >= span_x);
                  bin_in    = bin_ff + BinW'(1);
                  state_in  = ST_SUB;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SUB: begin
            sum_in   = sum_ff - (sub_en_ff ? SumW'(rd_ff) : '0);
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         store[CntW'(q_idx_x)] <= q_amp;
      end
      if (rd_en) begin
         rd_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      amp_in_reg : begin
         amp_ff    <= amp_in;
         idx_ff    <= idx_in;
         span_ff   <= span_in;
         last_ff   <= last_in;
         bin_ff    <= bin_in;
         sum_ff    <= sum_in;
         sub_en_ff <= sub_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/bna_divider.sv]
module bna_divider
   import bna_pkg::*;
#(
   parameter int MaxSpan = MAX_SPAN_DEF,
   parameter int MaxBins = MAX_BINS_DEF,
   parameter int BinW    = $clog2(MaxBins),
   parameter int CntW    = $clog2(2 * MaxSpan + 2),
   parameter int SumW    = AMP_W + CntW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  div_valid,
   output logic                  div_ready,
   input  logic [SumW-1:0]       div_sum,
   input  logic [CntW-1:0]       div_cnt,
   input  logic [BinW-1:0]       div_bin,
   input  logic                  div_end,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int RecipW = SumW + 1;
   localparam int ProdW  = SumW + RecipW;
   localparam int QdW    = SumW + CntW;
   localparam int Entries = 2 ** CntW;
   localparam logic [RecipW-1:0] RecipNum = '1;

   // floor((2^RecipW - 1) / d): estimate is exact or one short
   logic [RecipW-1:0] recip_table [Entries];

   assign recip_table[0] = '0;
   for (genvar Dv = 1; Dv < Entries; Dv++) begin : g_recip
      assign recip_table[Dv] = RecipW'(RecipNum / Dv);
   end

   logic              adv;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SumW-1:0]   n1_ff, n2_ff, n3_ff;
   logic [CntW-1:0]   d1_ff, d2_ff, d3_ff;
   logic [RecipW-1:0] r1_ff;
   logic [SumW-1:0]   q2_ff, q3_ff, qd3_ff;
   logic [BinW-1:0]   b1_ff, b2_ff, b3_ff, b4_ff;
   logic              e1_ff, e2_ff, e3_ff, e4_ff;
   logic [AMP_W-1:0]  amp4_ff;

   logic [ProdW-1:0]  prod;
   logic [QdW-1:0]    qd_full;
   logic [SumW-1:0]   rem;
   logic [SumW-1:0]   quo;

   assign adv       = !v4_ff || rsp_tready;
   assign div_ready = adv;

   assign prod    = ProdW'(n1_ff) * ProdW'(r1_ff);
   assign qd_full = QdW'(q2_ff) * QdW'(d2_ff);
   assign rem     = n3_ff - qd3_ff;
   assign quo     = (rem >= SumW'(d3_ff)) ? q3_ff + SumW'(1) : q3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff   <= div_sum + SumW'(div_cnt >> 1);
         d1_ff   <= div_cnt;
         r1_ff   <= recip_table[div_cnt];
         b1_ff   <= div_bin;
         e1_ff   <= div_end;

         q2_ff   <= prod[ProdW-1:RecipW];
         n2_ff   <= n1_ff;
         d2_ff   <= d1_ff;
         b2_ff   <= b1_ff;
         e2_ff   <= e1_ff;

         qd3_ff  <= qd_full[SumW-1:0];
         q3_ff   <= q2_ff;
         n3_ff   <= n2_ff;
         d3_ff   <= d2_ff;
         b3_ff   <= b2_ff;
         e3_ff   <= e2_ff;

         amp4_ff <= quo[AMP_W-1:0];
         b4_ff   <= b3_ff;
         e4_ff   <= e3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= div_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), BIN_NUMBER_W'(b4_ff), amp4_ff};
   assign rsp_tlast  = e4_ff;

endmodule

[rtl/bin_neighbour_average_core.sv]
// Smooths a spectral frame across its bins with an edge-truncated moving average.
// Request channel (req_): one bin amplitude per request, in bin order, tlast on the
// final bin of the frame; a frame is also closed at bin MaxBins-1.
// Response channel (rsp_): one result per bin, in bin order, carrying the rounded
// mean, the bin number and tlast on the frame's final bin.
// csr_wr_en/csr_wr_data set the half width; it is sampled at the first bin of a frame.
// A front end counts bins and latches the span, a 4-entry queue decouples it from the
// back end, which keeps the running window sum over a 2**CntW-entry store and feeds a
// 4-stage reciprocal divider whose last stage is the response register.
// Per bin the back end pops it, updates the window and hands a result to the divider once
// results flow (no hand-off while the window is still filling), then pops the next; at frame
// end each pending bin is handed off, then the bin leaving the window is removed.
// Path from the queue to rsp_: back-end pop, window update, hand-off, then the four divider
// stages.
// A stalled response holds the divider; the queue keeps taking requests until full.
// Reset (synchronous) empties queue and pipeline, restarts the bin count and sets the
// half width to 4; req_tready is low during reset. Store contents are not cleared.
module bin_neighbour_average_core
   import bna_pkg::*;
#(
   parameter int MaxSpan = MAX_SPAN_DEF,
   parameter int MaxBins = MAX_BINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SPAN_W-1:0]     csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [23:0] bin_amplitude
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [23:0] smoothed_amplitude, [36:24] bin_number
   output logic                  rsp_tlast
);

   localparam int BinW   = $clog2(MaxBins);
   localparam int CntW   = $clog2(2 * MaxSpan + 2);
   localparam int SumW   = AMP_W + CntW;
   localparam int EntryW = AMP_W + BinW + SPAN_W + 1;

   logic              q_push, q_pop, q_full, q_empty;
   logic [AMP_W-1:0]  push_amp, q_amp;
   logic [BinW-1:0]   push_idx, q_idx;
   logic [SPAN_W-1:0] push_span, q_span;
   logic              push_last, q_last;
   logic [EntryW-1:0] q_in, q_out;

   logic              div_valid, div_ready, div_end;
   logic [SumW-1:0]   div_sum;
   logic [CntW-1:0]   div_cnt;
   logic [BinW-1:0]   div_bin;

   bna_front #(
      .MaxSpan (MaxSpan),
      .MaxBins (MaxBins),
      .BinW    (BinW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata[AMP_W-1:0]),
      .req_tlast   (req_tlast),
      .q_full      (q_full),
      .q_push      (q_push),
      .push_amp    (push_amp),
      .push_idx    (push_idx),
      .push_span   (push_span),
      .push_last   (push_last)
   );

   assign q_in = {push_last, push_span, push_idx, push_amp};
   assign {q_last, q_span, q_idx, q_amp} = q_out;

   bna_queue #(
      .Width (EntryW),
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   bna_back #(
      .MaxSpan (MaxSpan),
      .MaxBins (MaxBins),
      .BinW    (BinW),
      .CntW    (CntW),
      .SumW    (SumW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_amp     (q_amp),
      .q_idx     (q_idx),
      .q_span    (q_span),
      .q_last    (q_last),
      .div_ready (div_ready),
      .div_valid (div_valid),
      .div_sum   (div_sum),
      .div_cnt   (div_cnt),
      .div_bin   (div_bin),
      .div_end   (div_end)
   );

   bna_divider #(
      .MaxSpan (MaxSpan),
      .MaxBins (MaxBins),
      .BinW    (BinW),
      .CntW    (CntW),
      .SumW    (SumW)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_valid  (div_valid),
      .div_ready  (div_ready),
      .div_sum    (div_sum),
      .div_cnt    (div_cnt),
      .div_bin    (div_bin),
      .div_end    (div_end),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_queue_state : assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue reports full and empty together");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_span_range : assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_span != '0) && (32'(push_span) <= MaxSpan))
      else $error("span outside its legal range");

   a_window_count : assert property (@(posedge clock) disable iff (reset)
      (div_valid && div_ready) |-> (div_cnt != '0))
      else $error("zero-bin window sent to divider");

endmodule

[tb/bin_neighbour_average_core_tb.sv]
module bin_neighbour_average_core_tb;
   import bna_pkg::*;

   localparam int STORE_DEPTH = 128;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_BINS = 240;
   localparam int QUIET_AFTER = 190;

   typedef struct packed {
      logic [AMP_W-1:0]        amp;
      logic [BIN_NUMBER_W-1:0] bin;
      logic                    fend;
   } smooth_type;

   typedef struct packed {
      logic              cfg_en;
      logic [SPAN_W-1:0] cfg_val;
      logic [AMP_W-1:0]  amp;
      logic              last;
      logic              typed;
      logic [AMP_W-1:0]  typed_amp;
   } bin_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [SPAN_W-1:0]     csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [23:0] bin_amplitude
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [23:0] smoothed_amplitude, [36:24] bin_number
   logic                  rsp_tlast;

   // predictor state
   logic [AMP_W-1:0]        amp_store [STORE_DEPTH];
   logic [BIN_NUMBER_W-1:0] bin_count;
   logic [SPAN_W-1:0]       span_now;
   logic [SPAN_W-1:0]       half_width_reg;
   smooth_type              smooth_q [$];

   bin_row_type directed_rows [$];
   smooth_type  want;
   int          err_count;
   int          idle_cycles;
   int          stall_left;
   bit          idle_on;

   bin_neighbour_average_core DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_W-1:0] v);
      if (v == 0) return SPAN_W'(1);
      if (v > MAX_SPAN_DEF) return SPAN_W'(MAX_SPAN_DEF);
      return v;
   endfunction

   // rounded mean of bins b-s..b+s, cut at bin 0 and at hi
   function automatic smooth_type average_bin(input int b, input int hi, input int s,
                                              input logic fend);
      int         lo;
      int         top;
      int         cnt;
      longint     total;
      smooth_type r;
      lo = (b >= s) ? b - s : 0;
      top = (b + s < hi) ? b + s : hi;
      cnt = top - lo + 1;
      total = 0;
      for (int j = lo; j <= top; j++) total += amp_store[j % STORE_DEPTH];
      r.amp = AMP_W'((total + cnt / 2) / cnt);
      r.bin = BIN_NUMBER_W'(b);
      r.fend = fend;
      return r;
   endfunction

   function automatic void predict_bin(input logic [AMP_W-1:0] amp, input logic last);
      int  i;
      int  s;
      bit  closing;
      i = bin_count;
      if (i == 0) span_now = clamp_span(half_width_reg);
      s = span_now;
      closing = last || (i == MAX_BINS_DEF - 1);
      amp_store[i % STORE_DEPTH] = amp;
      if (closing) begin
         for (int b = (i >= s) ? i - s : 0; b <= i; b++)
            smooth_q = {smooth_q, average_bin(b, i, s, b == i)};
         bin_count = 0;
      end else begin
         if (i >= s) smooth_q = {smooth_q, average_bin(i - s, i, s, 1'b0)};
         bin_count = bin_count + 1'b1;
      end
   endfunction

   function automatic logic [AMP_W-1:0] rand_amp();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return AMP_W'($urandom);
      endcase
   endfunction

   function automatic void add_row(input logic cfg_en, input logic [SPAN_W-1:0] cfg_val,
                                   input logic [AMP_W-1:0] amp, input logic last,
                                   input logic typed);
      bin_row_type r;
      r.cfg_en = cfg_en;
      r.cfg_val = cfg_val;
      r.amp = amp;
      r.last = last;
      r.typed = typed;
      r.typed_amp = amp;   // single-bin frames: the mean is the bin itself
      directed_rows = {directed_rows, r};
   endfunction

   // called at a falling edge; returns at a falling edge with the request still up
   task automatic send_bin(input logic [AMP_W-1:0] amp, input logic last,
                           input logic typed, input logic [AMP_W-1:0] typed_amp);
      int gap;
      if (idle_on && $urandom_range(3) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= amp;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_bin(amp, last);
      if (typed) smooth_q[$] = '{amp: typed_amp, bin: '0, fend: 1'b1};
      @(negedge clock);
   endtask

   // only written with nothing in flight
   task automatic write_half_width(input logic [SPAN_W-1:0] v);
      req_tvalid <= 1'b0;
      while (smooth_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      half_width_reg = v;
      csr_wr_en <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smooth_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result for bin %0d", rsp_tdata[36:24]));
         end else begin
            want = smooth_q.pop_front();
            if (rsp_tdata[AMP_W-1:0] !== want.amp)
               flag_mismatch($sformatf("bin %0d amplitude %h, want %h", want.bin,
                                       rsp_tdata[AMP_W-1:0], want.amp));
            if (rsp_tdata[AMP_W+BIN_NUMBER_W-1:AMP_W] !== want.bin)
               flag_mismatch($sformatf("bin number %0d, want %0d",
                                       rsp_tdata[AMP_W+BIN_NUMBER_W-1:AMP_W], want.bin));
            if (rsp_tlast !== want.fend)
               flag_mismatch($sformatf("bin %0d frame end %b, want %b", want.bin,
                                       rsp_tlast, want.fend));
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int sent;
      int frames;
      int flen;
      int pick;
      bin_row_type r;
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      err_count = 0;
      idle_cycles = 0;
      stall_left = 0;
      idle_on = 1'b1;
      bin_count = '0;
      span_now = SPAN_RESET;
      half_width_reg = HALF_WIDTH_RESET;

      // single-bin frames at reset span
      add_row(0, 0, 24'h000000, 1, 1);
      add_row(0, 0, 24'hFFFFFF, 1, 1);
      // zero half width acts as one; rounding of halves
      add_row(1, 0, 24'hFFFFFF, 0, 0);
      add_row(0, 0, 24'h000000, 0, 0);
      add_row(0, 0, 24'hFFFFFF, 0, 0);
      add_row(0, 0, 24'h000001, 1, 0);
      // widest span, frame shorter than the span
      add_row(1, 63, 24'h000001, 0, 0);
      add_row(0, 0, 24'hFFFFFF, 0, 0);
      add_row(0, 0, 24'h800000, 0, 0);
      add_row(0, 0, 24'h7FFFFF, 0, 0);
      add_row(0, 0, 24'h000003, 1, 0);
      // span change mid-frame only applies to the next frame
      add_row(1, 1, 24'h000010, 0, 0);
      add_row(0, 0, 24'h000020, 0, 0);
      add_row(0, 0, 24'h000030, 0, 0);
      add_row(1, 63, 24'h000040, 0, 0);
      add_row(0, 0, 24'h000050, 0, 0);
      add_row(0, 0, 24'h000060, 1, 0);
      add_row(0, 0, 24'h000005, 0, 0);
      add_row(0, 0, 24'h000006, 0, 0);
      add_row(0, 0, 24'h000007, 1, 0);
      add_row(0, 0, 24'h123456, 1, 1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         if (r.cfg_en) write_half_width(r.cfg_val);
         send_bin(r.amp, r.last, r.typed, r.typed_amp);
      end

      sent = 0;
      while (sent < RANDOM_BINS) begin
         pick = $urandom_range(5);
         if (pick == 0) write_half_width(0);
         else if (pick == 1) write_half_width(63);
         else if (pick == 2) write_half_width(SPAN_W'($urandom_range(1, 63)));
         else write_half_width(SPAN_W'($urandom_range(1, 8)));
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            pick = $urandom_range(9);
            if (pick < 2) flen = $urandom_range(1, 3);
            else if (pick < 9) flen = $urandom_range(4, 40);
            else flen = $urandom_range(60, 140);
            if (flen > RANDOM_BINS - sent) flen = RANDOM_BINS - sent;
            for (int k = 0; k < flen; k++) begin
               if (sent >= QUIET_AFTER) idle_on = 1'b0;
               send_bin(rand_amp(), k == flen - 1, 1'b0, '0);
               sent++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (smooth_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
rtl/bna_pkg.sv
rtl/bna_front.sv
rtl/bna_queue.sv
rtl/bna_back.sv
rtl/bna_divider.sv
rtl/bin_neighbour_average_core.sv
tb/bin_neighbour_average_core_tb.sv
